[rtl/lrgd_pkg.sv]
// Package for the linear regression gradient descent block.
// Widths, codes, state types and saturating helpers; depends on nothing.
package lrgd_pkg;

    localparam int MAX_POINTS = 64;
    localparam int FRAC_BITS  = 16;

    localparam int ADDR_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int DIV_W   = CNT_W + 1;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int X_W     = 16;
    localparam int Y_W     = 24;
    localparam int W_W     = 48;
    localparam int LR_W    = 32;
    localparam int IT_W    = 20;
    localparam int ACC_W   = 64;
    localparam int COST_W  = 63;
    localparam int SUM_W   = ACC_W + 2;
    localparam int PA_W    = W_W + X_W + 1;
    localparam int ERR_W   = ((W_W > Y_W + FRAC_BITS) ? W_W : Y_W + FRAC_BITS) + 2;
    localparam int MAG_W   = ERR_W - 1;
    localparam int H_W     = (MAG_W + 1) / 2;
    localparam int SQ_W    = 4 * H_W;
    localparam int SQX_W   = ((SQ_W > 2 * FRAC_BITS + COST_W) ? SQ_W
                             : 2 * FRAC_BITS + COST_W) + 1;
    localparam int EX_W    = MAG_W + X_W;
    localparam int DCNT_W  = $clog2(ACC_W);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W   = 32;
    localparam int PT_W    = X_W + Y_W;

    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRAIN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PREDICT = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 1'd1;

    localparam logic [LR_W-1:0] LR_RESET   = 32'd171799;
    localparam logic [IT_W-1:0] ITER_RESET = 20'd500000;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] ACC_HI = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] ACC_LO = -ACC_HI;
    localparam logic signed [SUM_W-1:0] W_HI = {{(SUM_W-W_W+1){1'b0}}, {(W_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] W_LO = ~W_HI;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_DIV,
        S_STEP,
        S_PRED,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        K_DROP,
        K_EMPTY,
        K_TRAIN,
        K_PRED
    } t_kind;

    // accumulated sums of one pass over the stored points
    typedef struct packed {
        logic signed [ACC_W-1:0] gw;
        logic signed [ACC_W-1:0] gb;
        logic [ACC_W-1:0]        sum;
        logic                    sat;
    } t_pass_res;

    // saturating add, both operands within +-(2^63-1)
    function automatic logic signed [ACC_W-1:0] sadd(input logic signed [ACC_W-1:0] a,
                                                     input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s > ACC_HI) begin
            return ACC_HI[ACC_W-1:0];
        end
        if (s < ACC_LO) begin
            return ACC_LO[ACC_W-1:0];
        end
        return s[ACC_W-1:0];
    endfunction

    // clamp to the signed 48-bit weight range
    function automatic logic signed [W_W-1:0] sat_w(input logic signed [SUM_W-1:0] v);
        if (v > W_HI) begin
            return W_HI[W_W-1:0];
        end
        if (v < W_LO) begin
            return W_LO[W_W-1:0];
        end
        return v[W_W-1:0];
    endfunction

endpackage

[rtl/linear_regression_gradient_descent.sv]
// Linear regression by batch gradient descent: top level with sequencer.
// Depends on lrgd_pkg, lrgd_ram, lrgd_div and lrgd_pass.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one command transaction:
//   append a point, append then train, or predict. Output channel
//   (o_out_valid / i_out_ready) carries one result transaction.
//   Config port: i_cfg_we with i_cfg_idx selects learning rate (0) or
//   iteration count (1), written from i_cfg_data; write only while idle.
// Sequence
//   An append that stores its point yields no result.
//   Predict: w*x is registered in S_PRED; the result is loaded from S_DONE.
//   Train over m points with N iterations: N+1 passes over the point RAM,
//   each made of m reads, the pipeline drain, then the 64-step bit-serial
//   divides; after every pass but the last, the step updates slope and
//   intercept. The point RAM read port and the divider set the pass length.
// Reset
//   Empties the point store, zeroes slope and intercept and loads the
//   default learning rate and iteration count. No clearing pass is needed.
// Stalls
//   The result sits in an output register until taken; appends keep
//   being accepted meanwhile, a command with a result waits for the slot.
module linear_regression_gradient_descent import lrgd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [X_W-1:0]        i_x_value,
    input  logic [Y_W-1:0]        i_y_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STAT_W-1:0]     o_status,
    output logic signed [W_W-1:0] o_weight,
    output logic signed [W_W-1:0] o_bias,
    output logic [COST_W-1:0]     o_final_cost,
    output logic [COST_W-1:0]     o_least_cost,
    output logic signed [W_W-1:0] o_prediction,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_state r_state, n_state;

    logic [LR_W-1:0]         r_lr;
    logic [IT_W-1:0]         r_iter_cfg;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_rd_idx;
    logic                    r_v0;
    logic [IT_W-1:0]         r_iter;
    logic signed [W_W-1:0]   r_w;
    logic signed [W_W-1:0]   r_b;
    t_kind                   r_kind;
    logic                    r_dropped;
    logic [COST_W-1:0]       r_final;
    logic [ACC_W-1:0]        r_least;
    logic [X_W-1:0]          r_px;
    logic signed [PA_W-1:0]  r_pp;
    logic [2:0]              r_sk;
    logic [ACC_W-1:0]        r_prod;
    logic [ACC_W-1:0]        r_phi;

    logic                    r_o_valid;
    logic [STAT_W-1:0]       r_o_status;
    logic signed [W_W-1:0]   r_o_weight;
    logic signed [W_W-1:0]   r_o_bias;
    logic [COST_W-1:0]       r_o_final;
    logic [COST_W-1:0]       r_o_least;
    logic signed [W_W-1:0]   r_o_pred;

    // control decoded from the state
    logic                    in_acc;
    logic                    full;
    logic                    ram_we;
    logic                    issue;
    logic                    pass_end;
    logic                    pass_clear;
    logic                    div_start;
    logic                    out_free;

    logic [PT_W-1:0]         ram_rdata;
    logic                    pass_busy;
    t_pass_res               pass_res;

    logic [ACC_W-1:0]        gw_mag;
    logic [ACC_W-1:0]        gb_mag;
    logic [ACC_W-1:0]        qw;
    logic [ACC_W-1:0]        qb;
    logic [ACC_W-1:0]        qc;
    logic                    div_done;
    logic                    div_done_b;
    logic                    div_done_c;
    logic [ACC_W-1:0]        cost;

    logic [LR_W-1:0]         mul_b;
    logic [ACC_W-1:0]        step_raw;
    logic [ACC_W-1:0]        step_mag;
    logic                    step_neg;
    logic signed [W_W-1:0]   step_base;
    logic signed [SUM_W-1:0] step_sum;
    logic signed [W_W-1:0]   step_new;
    logic signed [W_W-1:0]   pred_val;

    assign full     = r_count == CNT_W'(MAX_POINTS);
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_o_valid || i_out_ready;
    assign pass_end = (r_rd_idx == r_count) && !r_v0 && !pass_busy;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_func)
                        FUNC_APPEND:  n_state = full ? S_DONE : S_IDLE;
                        FUNC_TRAIN:   n_state = S_PASS;
                        FUNC_PREDICT: n_state = S_PRED;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_PASS: if (pass_end) n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = (r_iter == r_iter_cfg) ? S_DONE : S_STEP;
                end
            end
            S_STEP: if (r_sk == 3'd4) n_state = S_PASS;
            S_PRED: n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        issue      = 1'b0;
        pass_clear = 1'b0;
        div_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                ram_we     = in_acc && !full
                           && (i_func == FUNC_APPEND || i_func == FUNC_TRAIN);
                pass_clear = in_acc && i_func == FUNC_TRAIN;
            end
            S_PASS: begin
                issue     = r_rd_idx != r_count;
                div_start = pass_end;
            end
            S_STEP:  pass_clear = r_sk == 3'd4;
            default: ;
        endcase
    end

    lrgd_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_x_value, i_y_value}),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    lrgd_pass u_pass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (pass_clear),
        .i_valid (r_v0),
        .i_x     (ram_rdata[PT_W-1:Y_W]),
        .i_y     (ram_rdata[Y_W-1:0]),
        .i_w     (r_w),
        .i_b     (r_b),
        .o_busy  (pass_busy),
        .o_res   (pass_res)
    );

    // gradient magnitudes; signs are reapplied in the step
    assign gw_mag = pass_res.gw[ACC_W-1] ? ACC_W'(-pass_res.gw) : ACC_W'(pass_res.gw);
    assign gb_mag = pass_res.gb[ACC_W-1] ? ACC_W'(-pass_res.gb) : ACC_W'(pass_res.gb);

    lrgd_div u_div_w (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (gw_mag),
        .i_divisor  (DIV_W'(r_count)),
        .o_done     (div_done),
        .o_quotient (qw)
    );

    lrgd_div u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (gb_mag),
        .i_divisor  (DIV_W'(r_count)),
        .o_done     (div_done_b),
        .o_quotient (qb)
    );

    // cost divides by 2m
    lrgd_div u_div_c (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (pass_res.sum),
        .i_divisor  ({r_count, 1'b0}),
        .o_done     (div_done_c),
        .o_quotient (qc)
    );

    assign cost = pass_res.sat ? ACC_MAX : qc;

    // step: lr * |d| / 2^32 over two 32x32 products, w at sk 2, b at sk 4
    always_comb begin
        case (r_sk)
            3'd0:    mul_b = qw[ACC_W-1:LR_W];
            3'd1:    mul_b = qw[LR_W-1:0];
            3'd2:    mul_b = qb[ACC_W-1:LR_W];
            3'd3:    mul_b = qb[LR_W-1:0];
            default: mul_b = '0;
        endcase
        step_raw  = r_phi + ACC_W'(r_prod[ACC_W-1:LR_W]);
        step_mag  = step_raw[ACC_W-1] ? ACC_MAX : step_raw;
        step_neg  = (r_sk == 3'd2) ? pass_res.gw[ACC_W-1] : pass_res.gb[ACC_W-1];
        step_base = (r_sk == 3'd2) ? r_w : r_b;
        // negative gradient moves the value up
        step_sum  = step_neg ? SUM_W'(step_base) + SUM_W'(step_mag)
                             : SUM_W'(step_base) - SUM_W'(step_mag);
        step_new  = sat_w(step_sum);
        pred_val  = sat_w(SUM_W'(r_pp) + SUM_W'(r_b));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lr       <= LR_RESET;
            r_iter_cfg <= ITER_RESET;
            r_count    <= '0;
            r_v0       <= 1'b0;
            r_w        <= '0;
            r_b        <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEARNING_RATE:   r_lr       <= i_cfg_data[LR_W-1:0];
                    CFG_ITERATION_COUNT: r_iter_cfg <= i_cfg_data[IT_W-1:0];
                    default: ;
                endcase
            end

            if (ram_we) begin
                r_count <= r_count + 1'b1;
            end

            r_v0 <= issue;
            if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end

            // a new result fills the slot, a taken one empties it
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_dropped <= full;
                        r_px      <= i_x_value;
                        if (i_func == FUNC_TRAIN) begin
                            // a train stores its point first unless the store is full, so m is never 0
                            r_kind   <= K_TRAIN;
                            r_w      <= '0;
                            r_b      <= '0;
                            r_iter   <= '0;
                            r_least  <= ACC_MAX;
                            r_rd_idx <= '0;
                        end else begin
                            r_kind <= K_DROP;
                        end
                    end
                end
                S_DIV: begin
                    r_sk <= '0;
                    if (div_done) begin
                        r_final <= cost[COST_W-1:0];
                        if (r_iter != '0 && cost < r_least) begin
                            r_least <= cost;
                        end
                    end
                end
                S_STEP: begin
                    r_sk   <= r_sk + 1'b1;
                    r_prod <= ACC_W'(r_lr) * ACC_W'(mul_b);
                    r_phi  <= r_prod;
                    if (r_sk == 3'd2) begin
                        r_w <= step_new;
                    end
                    if (r_sk == 3'd4) begin
                        r_b      <= step_new;
                        r_iter   <= r_iter + 1'b1;
                        r_rd_idx <= '0;
                    end
                end
                S_PRED: begin
                    r_kind <= K_PRED;
                    r_pp   <= $signed(r_w) * $signed({1'b0, r_px});
                end
                S_DONE: begin
                    if (out_free && r_kind == K_TRAIN) begin
                        r_count <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // result fields; loaded once the output slot is free
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_status <= STAT_OK;
            r_o_weight <= '0;
            r_o_bias   <= '0;
            r_o_final  <= '0;
            r_o_least  <= '0;
            r_o_pred   <= '0;
            case (r_kind)
                K_DROP:  r_o_status <= STAT_FULL;
                K_EMPTY: r_o_status <= STAT_EMPTY;
                K_TRAIN: begin
                    r_o_status <= r_dropped ? STAT_FULL : STAT_OK;
                    r_o_weight <= r_w;
                    r_o_bias   <= r_b;
                    r_o_final  <= r_final;
                    r_o_least  <= r_least[COST_W-1:0];
                end
                K_PRED: begin
                    r_o_weight <= r_w;
                    r_o_bias   <= r_b;
                    r_o_pred   <= pred_val;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_weight     = r_o_weight;
    assign o_bias       = r_o_bias;
    assign o_final_cost = r_o_final;
    assign o_least_cost = r_o_least;
    assign o_prediction = r_o_pred;

endmodule

[rtl/lrgd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Standalone; no package needed.
module lrgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lrgd_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lrgd_pkg for widths.
module lrgd_div import lrgd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ACC_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [ACC_W-1:0] o_quotient
);

    logic [ACC_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_W:0]    sh;
    logic [DIV_W:0]    diff;
    logic              ge;

    always_comb begin
        sh   = {r_rem, r_quo[ACC_W-1]};
        ge   = sh >= {1'b0, i_divisor};
        diff = sh - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
                r_quo <= {r_quo[ACC_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/lrgd_pass.sv]
// Per-point pipeline: error, gradient terms, squared error and their sums.
// Depends on lrgd_pkg; fed from the point RAM by the top level.
module lrgd_pass import lrgd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_valid,
    input  logic [X_W-1:0]        i_x,
    input  logic [Y_W-1:0]        i_y,
    input  logic signed [W_W-1:0] i_w,
    input  logic signed [W_W-1:0] i_b,
    output logic                  o_busy,
    output t_pass_res             o_res
);

    // stage A: w*x
    logic                     r_va;
    logic signed [PA_W-1:0]   r_pa;
    logic [X_W-1:0]           r_xa;
    logic [Y_W-1:0]           r_ya;
    // stage B: error
    logic                     r_vb;
    logic signed [ERR_W-1:0]  r_e;
    logic [X_W-1:0]           r_xb;
    // stage C: products
    logic                     r_vc;
    logic signed [ERR_W-1:0]  r_ec;
    logic                     r_en;
    logic [EX_W-1:0]          r_ex;
    logic [2*H_W-1:0]         r_hh;
    logic [2*H_W-1:0]         r_hl;
    logic [2*H_W-1:0]         r_ll;
    // stage D: square term
    logic                     r_vd;
    logic [COST_W-1:0]        r_term;
    // sums
    logic signed [ACC_W-1:0]  r_gw;
    logic signed [ACC_W-1:0]  r_gb;
    logic [ACC_W-1:0]         r_sum;
    logic                     r_sat;

    logic signed [SUM_W-1:0]  pred_sum;
    logic signed [W_W-1:0]    pred;
    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         mag_full;
    logic [MAG_W-1:0]         mag;
    logic [2*H_W-1:0]         mag_p;
    logic [ACC_W-1:0]         term_x;
    logic signed [ACC_W-1:0]  gw_term;
    logic signed [ACC_W-1:0]  gb_term;
    logic [SQ_W-1:0]          sq;
    logic [SQX_W-1:0]         sq_sh;
    logic [COST_W-1:0]        sq_term;
    logic [ACC_W-1:0]         room;

    always_comb begin
        pred_sum = SUM_W'(r_pa) + SUM_W'(i_b);
        pred     = sat_w(pred_sum);
        err      = $signed({{(ERR_W-W_W){pred[W_W-1]}}, pred})
                 - $signed({{(ERR_W-Y_W-FRAC_BITS){1'b0}}, r_ya, {FRAC_BITS{1'b0}}});

        mag_full = r_e[ERR_W-1] ? ERR_W'(-r_e) : ERR_W'(r_e);
        mag      = mag_full[MAG_W-1:0];
        mag_p    = (2*H_W)'(mag);

        term_x   = (r_ex > EX_W'(ACC_MAX)) ? ACC_MAX : r_ex[ACC_W-1:0];
        gw_term  = r_en ? -$signed(term_x) : $signed(term_x);
        gb_term  = ACC_W'(r_ec);
        sq       = (SQ_W'(r_hh) << (2*H_W)) + (SQ_W'(r_hl) << (H_W+1)) + SQ_W'(r_ll);
        sq_sh    = SQX_W'(sq) >> (2*FRAC_BITS);
        sq_term  = (|sq_sh[SQX_W-1:COST_W]) ? ACC_MAX[COST_W-1:0] : sq_sh[COST_W-1:0];

        room     = ACC_MAX - r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end

        r_pa <= $signed(i_w) * $signed({1'b0, i_x});
        r_xa <= i_x;
        r_ya <= i_y;

        r_e  <= err;
        r_xb <= r_xa;

        r_ec <= r_e;
        r_en <= r_e[ERR_W-1];
        r_ex <= EX_W'(mag) * EX_W'(r_xb);
        r_hh <= mag_p[2*H_W-1:H_W] * mag_p[2*H_W-1:H_W];
        r_hl <= mag_p[2*H_W-1:H_W] * mag_p[H_W-1:0];
        r_ll <= mag_p[H_W-1:0] * mag_p[H_W-1:0];

        r_term <= sq_term;

        if (i_clear) begin
            r_gw  <= '0;
            r_gb  <= '0;
            r_sum <= '0;
            r_sat <= 1'b0;
        end else begin
            if (r_vc) begin
                r_gw <= sadd(r_gw, gw_term);
                r_gb <= sadd(r_gb, gb_term);
            end
            if (r_vd && !r_sat) begin
                // once saturated the cost is pinned at its maximum
                if (ACC_W'(r_term) > room) begin
                    r_sat <= 1'b1;
                end else begin
                    r_sum <= r_sum + ACC_W'(r_term);
                end
            end
        end
    end

    assign o_busy    = r_va | r_vb | r_vc | r_vd;
    assign o_res.gw  = r_gw;
    assign o_res.gb  = r_gb;
    assign o_res.sum = r_sum;
    assign o_res.sat = r_sat;

endmodule

[tb/linear_regression_gradient_descent_tb.sv]
// Testbench for linear_regression_gradient_descent: directed and random commands
// checked against a self-contained fixed-point gradient descent predictor.
// Depends on lrgd_pkg and the RTL of the block.
module linear_regression_gradient_descent_tb;
    import lrgd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint W48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint W48_MIN = -W48_MAX - 1;

    typedef struct {
        logic [STAT_W-1:0]     status;
        logic signed [W_W-1:0] weight;
        logic signed [W_W-1:0] bias;
        logic [COST_W-1:0]     final_cost;
        logic [COST_W-1:0]     least_cost;
        logic signed [W_W-1:0] prediction;
    } t_fit_result;

    // Scoreboard: mirrors the point store, kept line and registers, and
    // queues the result each accepted command should produce.
    class t_fit_scoreboard;
        int unsigned sizes[MAX_POINTS];
        int unsigned prices[MAX_POINTS];
        int unsigned npoints;
        longint      slope;
        longint      icept;
        longint unsigned rate;
        int unsigned iters;
        t_fit_result pending_q[$];
        int errors;
        int results;
        int trains;
        int drops;

        function new();
            npoints = 0;
            slope = 0;
            icept = 0;
            rate = LR_RESET;
            iters = ITER_RESET;
            errors = 0;
            results = 0;
            trains = 0;
            drops = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_LEARNING_RATE) begin
                rate = data;
            end else begin
                iters = data[IT_W-1:0];
            end
        endfunction

        // append an expected result at the tail of the queue
        function void expect_result(t_fit_result r);
            pending_q = {pending_q, r};
        endfunction

        function longint clamp48(longint v);
            if (v > W48_MAX) return W48_MAX;
            if (v < W48_MIN) return W48_MIN;
            return v;
        endfunction

        function longint add_sat(longint a, longint b);
            logic signed [64:0] s;
            s = a;
            s = s + b;
            if (s > I64_MAX) return I64_MAX;
            if (s < -I64_MAX) return -I64_MAX;
            return s[63:0];
        endfunction

        function longint line_at(longint w, longint b, int unsigned x);
            return clamp48(w * longint'(x) + b);
        endfunction

        function longint residual(longint w, longint b, int i);
            return line_at(w, b, sizes[i]) - (longint'(prices[i]) <<< FRAC_BITS);
        endfunction

        // e*x with symmetric saturation
        function longint weigh_by_size(longint e, int unsigned x);
            logic [127:0] p;
            longint unsigned mag;
            longint r;
            mag = (e < 0) ? -e : e;
            p = mag;
            p = p * x;
            r = (p > I64_MAX) ? I64_MAX : longint'(p[63:0]);
            return (e < 0) ? -r : r;
        endfunction

        function longint unsigned square_term(longint e);
            logic [127:0] sq;
            longint unsigned mag;
            mag = (e < 0) ? -e : e;
            sq = mag;
            sq = (sq * sq) >> (2 * FRAC_BITS);
            if (sq > I64_MAX) return I64_MAX;
            return sq[63:0];
        endfunction

        function longint unsigned cost_at(longint w, longint b);
            longint unsigned sum;
            longint unsigned t;
            sum = 0;
            for (int i = 0; i < npoints; i++) begin
                t = square_term(residual(w, b, i));
                if (t > I64_MAX - sum) return I64_MAX;
                sum += t;
            end
            return sum / (2 * longint'(npoints));
        endfunction

        // |d|*rate/2^32 truncated, capped, sign of d
        function longint scaled_step(longint d);
            logic [127:0] r;
            longint unsigned mag;
            longint s;
            mag = (d < 0) ? -d : d;
            r = mag;
            r = (r * rate) >> 32;
            s = (r > I64_MAX) ? I64_MAX : longint'(r[63:0]);
            return (d < 0) ? -s : s;
        endfunction

        // Command accepted by the block: update mirror, queue any result.
        function void note_command(logic [FUNC_W-1:0] f, int unsigned x, int unsigned y);
            t_fit_result r;
            bit dropped;
            longint w, b, gw, gb;
            longint unsigned fc, least;
            r = '{default: 0};
            dropped = 0;
            if (f == FUNC_UNUSED) return;
            if (f == FUNC_PREDICT) begin
                r.weight = slope;
                r.bias = icept;
                r.prediction = line_at(slope, icept, x);
                expect_result(r);
                return;
            end
            if (npoints < MAX_POINTS) begin
                sizes[npoints] = x;
                prices[npoints] = y;
                npoints++;
            end else begin
                dropped = 1;
                drops++;
            end
            if (f == FUNC_APPEND) begin
                if (dropped) begin
                    r.status = STAT_FULL;
                    expect_result(r);
                end
                return;
            end
            // train over the stored points, starting from a flat line
            trains++;
            w = 0;
            b = 0;
            least = I64_MAX;
            fc = cost_at(0, 0);
            for (int unsigned it = 0; it < iters; it++) begin
                gw = 0;
                gb = 0;
                for (int i = 0; i < npoints; i++) begin
                    gw = add_sat(gw, weigh_by_size(residual(w, b, i), sizes[i]));
                    gb = add_sat(gb, residual(w, b, i));
                end
                gw = gw / longint'(npoints);
                gb = gb / longint'(npoints);
                w = clamp48(add_sat(w, -scaled_step(gw)));
                b = clamp48(add_sat(b, -scaled_step(gb)));
                fc = cost_at(w, b);
                if (fc < least) least = fc;
            end
            slope = w;
            icept = b;
            npoints = 0;
            r.status = dropped ? STAT_FULL : STAT_OK;
            r.weight = w;
            r.bias = b;
            r.final_cost = fc[COST_W-1:0];
            r.least_cost = least[COST_W-1:0];
            expect_result(r);
        endfunction

        function void check_result(t_fit_result got);
            t_fit_result exp_r;
            results++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result transaction status=%0d", $time, got.status);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.status !== exp_r.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                errors++;
            end
            if (got.weight !== exp_r.weight) begin
                $display("%0t: weight exp %0d got %0d", $time, exp_r.weight, got.weight);
                errors++;
            end
            if (got.bias !== exp_r.bias) begin
                $display("%0t: bias exp %0d got %0d", $time, exp_r.bias, got.bias);
                errors++;
            end
            if (got.final_cost !== exp_r.final_cost) begin
                $display("%0t: final_cost exp %0d got %0d", $time,
                         exp_r.final_cost, got.final_cost);
                errors++;
            end
            if (got.least_cost !== exp_r.least_cost) begin
                $display("%0t: least_cost exp %0d got %0d", $time,
                         exp_r.least_cost, got.least_cost);
                errors++;
            end
            if (got.prediction !== exp_r.prediction) begin
                $display("%0t: prediction exp %0d got %0d", $time,
                         exp_r.prediction, got.prediction);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_in_valid = 0;
    logic                  o_in_ready;
    logic [FUNC_W-1:0]     i_func = FUNC_APPEND;
    logic [X_W-1:0]        i_x_value = '0;
    logic [Y_W-1:0]        i_y_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 0;
    logic [STAT_W-1:0]     o_status;
    logic signed [W_W-1:0] o_weight;
    logic signed [W_W-1:0] o_bias;
    logic [COST_W-1:0]     o_final_cost;
    logic [COST_W-1:0]     o_least_cost;
    logic signed [W_W-1:0] o_prediction;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_LEARNING_RATE;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    t_fit_scoreboard sb = new();
    bit calm = 0;          // no idling on either side while set
    int sent = 0;

    linear_regression_gradient_descent dut (.*);

    always #5 i_clk = ~i_clk;

    // Generous fixed limit: many times the slowest expected run.
    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    // Send one command transaction; returns at the accepting edge.
    task automatic send_cmd(logic [FUNC_W-1:0] f, int unsigned x, int unsigned y);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 31) begin
            i_in_valid <= 0;
            do @(negedge i_clk); while ($urandom_range(99) < 31);
        end
        i_in_valid <= 1;
        i_func <= f;
        i_x_value <= x;
        i_y_value <= y;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_command(f, x, y);
        sent++;
    endtask

    // Hold input idle until every queued result has arrived, plus settle time
    // since a stored append shows no result.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, data);
    endtask

    function automatic int unsigned rand_size();
        return ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(300);
    endfunction

    function automatic int unsigned rand_price();
        return ($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF) : $urandom_range(5000);
    endfunction

    // Receiver: random back-pressure, one long hold-off while input keeps coming.
    initial begin
        t_fit_result got;
        int cyc;
        bit held;
        cyc = 0;
        held = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (!held && sb.results >= 40) begin
                held = 1;
                i_out_ready <= 0;
                repeat (600) @(negedge i_clk);
            end
            i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got.status = o_status;
                got.weight = o_weight;
                got.bias = o_bias;
                got.final_cost = o_final_cost;
                got.least_cost = o_least_cost;
                got.prediction = o_prediction;
                sb.check_result(got);
            end
        end
    end

    initial begin
        int unsigned nappend;
        int unsigned budget;
        logic [CFG_W-1:0] lr;
        logic [IT_W-1:0]  its;
        bit no_train;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: default learning rate, short training
        write_reg(CFG_ITERATION_COUNT, 3);
        send_cmd(FUNC_PREDICT, 0, 0);
        send_cmd(FUNC_PREDICT, 16'hFFFF, 24'hFFFFFF);
        send_cmd(FUNC_APPEND, 0, 0);
        send_cmd(FUNC_APPEND, 16'hFFFF, 24'hFFFFFF);
        send_cmd(FUNC_TRAIN, 1234, 5678);
        send_cmd(FUNC_PREDICT, 16'hFFFF, 0);
        send_cmd(FUNC_PREDICT, 0, 24'hFFFFFF);
        send_cmd(FUNC_UNUSED, 16'hFFFF, 24'hFFFFFF);
        send_cmd(FUNC_TRAIN, 16'hFFFF, 24'hFFFFFF);   // single point
        send_cmd(FUNC_PREDICT, 100, 0);
        drain();
        // zero iterations at the largest rate
        write_reg(CFG_ITERATION_COUNT, 0);
        write_reg(CFG_LEARNING_RATE, 32'hFFFF_FFFF);
        send_cmd(FUNC_APPEND, 100, 200);
        send_cmd(FUNC_TRAIN, 300, 900);
        send_cmd(FUNC_PREDICT, 50, 0);
        drain();
        // rate zero, one step; then a saturating large rate
        write_reg(CFG_LEARNING_RATE, 0);
        write_reg(CFG_ITERATION_COUNT, 1);
        send_cmd(FUNC_TRAIN, 16'hFFFF, 24'hFFFFFF);
        send_cmd(FUNC_PREDICT, 16'hFFFF, 0);
        drain();
        write_reg(CFG_LEARNING_RATE, 32'hFFFF_FFFF);
        write_reg(CFG_ITERATION_COUNT, 6);
        send_cmd(FUNC_APPEND, 16'hFFFF, 24'hFFFFFF);
        send_cmd(FUNC_TRAIN, 16'hFFFF, 0);
        send_cmd(FUNC_PREDICT, 16'hFFFF, 0);
        drain();

        // random phases, each with its own register setting
        for (int ph = 0; ph < 10; ph++) begin
            no_train = (ph == 5);
            calm = (ph == 3);
            case (ph % 5)
                0: lr = $urandom_range(32'h0010_0000);
                1: lr = $urandom;
                2: lr = 0;
                3: lr = 32'hFFFF_FFFF;
                default: lr = $urandom_range(32'h0100_0000, 32'h0000_1000);
            endcase
            if (no_train) begin
                its = 20'hFFFFF;     // never trained with: far too slow
            end else if (ph == 7) begin
                its = 0;
            end else begin
                its = $urandom_range(12, 1);
            end
            write_reg(CFG_LEARNING_RATE, lr);
            write_reg(CFG_ITERATION_COUNT, its);
            budget = sent + 130;
            while (sent < budget) begin
                if ($urandom_range(9) == 0) begin
                    // noise: predicts and unused codes
                    if ($urandom_range(2) == 0) begin
                        send_cmd(FUNC_UNUSED, $urandom_range(65535), $urandom_range(24'hFFFFFF));
                    end else begin
                        send_cmd(FUNC_PREDICT, $urandom_range(65535),
                                 $urandom_range(24'hFFFFFF));
                    end
                    continue;
                end
                nappend = ($urandom_range(11) == 0) ? $urandom_range(70, 60)
                                                    : $urandom_range(8);
                for (int k = 0; k < nappend; k++) begin
                    send_cmd(FUNC_APPEND, rand_size(), rand_price());
                end
                if (no_train) begin
                    send_cmd(FUNC_PREDICT, rand_size(), rand_price());
                end else begin
                    send_cmd(FUNC_TRAIN, rand_size(), rand_price());
                    repeat ($urandom_range(2)) send_cmd(FUNC_PREDICT, rand_size(), 0);
                end
            end
            drain();
        end
        calm = 0;

        repeat (30) @(posedge i_clk);
        if (sb.pending_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending_q.size());
            sb.errors++;
        end
        $display("Ran %0d commands: %0d trains, %0d dropped points, %0d results checked.",
                 sent, sb.trains, sb.drops, sb.results);
        $display("Settings swept learning rate 0..max, iterations 0..12, full-store cases.");
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/lrgd_pkg.sv
rtl/lrgd_ram.sv
rtl/lrgd_div.sv
rtl/lrgd_pass.sv
rtl/linear_regression_gradient_descent.sv
tb/linear_regression_gradient_descent_tb.sv
